// File: hdl/nearest_neighbor_search_defines.svh
// Assertion macros shared by the nearest-neighbor search RTL.
`ifndef NEAREST_NEIGHBOR_SEARCH_DEFINES_SVH
`define NEAREST_NEIGHBOR_SEARCH_DEFINES_SVH

// Checks that a condition implies another one in the same cycle.
`define NNS_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Checks that a condition implies another one in the following cycle.
`define NNS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/nns_pkg.sv
// Shared types and constants of the nearest-neighbor search block.
package nns_pkg;

    // Default sizes of the reference store.
    localparam int DEF_MAX_RECORDS  = 256;
    localparam int DEF_MAX_FEATURES = 16;

    // Fixed field widths of the channels.
    localparam int VALUE_W    = 16;
    localparam int REC_IDX_W  = 8;
    localparam int FEAT_IDX_W = 4;
    localparam int DIST_W     = 36;
    localparam int SQ_W       = 32;
    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 9;
    localparam int FCOUNT_W   = 5;

    // Largest distance that the result can carry.
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Feed modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_RECORD_COUNT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;     // a feed beat is accepted this cycle
        logic start;     // clear the scan counters
        logic step;      // issue one feature read of the scan
        logic load_out;  // copy the best match into the output register
    } nns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_last; // the current read is the final one of the scan
        logic done;       // best match holds the final answer
    } nns_stat_t;

    // Per-read tags that travel down the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first_feat;
        logic last_feat;
        logic first_rec;
        logic last_all;
    } nns_tag_t;

endpackage

// File: hdl/nns_if.sv
// Channel interfaces of the nearest-neighbor search block.
interface nns_feed_if;
    import nns_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [REC_IDX_W-1:0]         record_index;
    logic [FEAT_IDX_W-1:0]        feature_index;
    logic signed [VALUE_W-1:0]    value;
    logic                         last;

    modport source (output valid, mode, record_index, feature_index, value, last,
                    input ready);
    modport sink   (input valid, mode, record_index, feature_index, value, last,
                    output ready);
endinterface

interface nns_result_if;
    import nns_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REC_IDX_W-1:0]  best_record;
    logic [DIST_W-1:0]     best_distance_sq;

    modport source (output valid, best_record, best_distance_sq, input ready);
    modport sink   (input valid, best_record, best_distance_sq, output ready);
endinterface

interface nns_cfg_if;
    import nns_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REG_IDX_W-1:0]   index;
    logic [REG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/nearest_neighbor_search.sv
// Top level of the nearest-neighbor search block.
//
//   Channel  Role    Beat contents
//   feed     sink    mode, record_index, feature_index, value, last
//   result   source  best_record, best_distance_sq
//   cfg      sink    index (0 record_count, 1 feature_count), data
//
// Load and query feature beats are taken only while no search runs.
// A query beat with last set starts a scan that issues one store read per
// cycle, record_count * feature_count reads in all, set by the single read
// port of the reference store, then drains through the distance pipeline.
// Reset clears control state only; the stores need no clearing pass.
// A result waiting in the output register does not stop new feed beats.
`include "nearest_neighbor_search_defines.svh"

module nearest_neighbor_search #(
    parameter int MAX_RECORDS  = nns_pkg::DEF_MAX_RECORDS,
    parameter int MAX_FEATURES = nns_pkg::DEF_MAX_FEATURES
) (
    input  logic        clk,
    input  logic        rst_n,
    nns_feed_if.sink    feed,
    nns_result_if.source result,
    nns_cfg_if.sink     cfg
);
    import nns_pkg::*;

    nns_cmd_t  cmd;
    nns_stat_t stat;
    logic      cfg_write;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    nns_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed_valid   (feed.valid),
        .feed_mode    (feed.mode),
        .feed_last    (feed.last),
        .feed_ready   (feed.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    nns_datapath #(
        .MAX_RECORDS  (MAX_RECORDS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .feed_mode          (feed.mode),
        .feed_record_index  (feed.record_index),
        .feed_feature_index (feed.feature_index),
        .feed_value         (feed.value),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .best_record        (result.best_record),
        .best_distance_sq   (result.best_distance_sq)
    );

    // A new result appears only after the controller loaded the output register.
    `NNS_ASSERT_SAME(a_result_from_load, clk, rst_n, $rose(result.valid), $past(cmd.load_out))
    // No store write may land while the scan reads the stores.
    `NNS_ASSERT_SAME(a_no_write_in_scan, clk, rst_n, cmd.step, !cmd.write)
    // A scan starts issuing reads right after it is started.
    `NNS_ASSERT_NEXT(a_start_then_step, clk, rst_n, cmd.start, cmd.step)

endmodule

// File: hdl/nns_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nns_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/nns_ctrl.sv
// Controller state machine of the nearest-neighbor search block.
module nns_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feed_valid,
    input  logic              feed_mode,
    input  logic              feed_last,
    output logic              feed_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output nns_pkg::nns_cmd_t cmd,
    input  nns_pkg::nns_stat_t stat
);
    import nns_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   feed_fire;

    assign feed_ready = (state_reg == ST_IDLE);
    assign feed_fire  = feed_valid && feed_ready;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd.write    = feed_fire;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (feed_fire && feed_mode == MODE_QUERY && feed_last)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register is full from its load until the sink takes the beat.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: hdl/nns_datapath.sv
// Stores, scan counters, distance pipeline and best-match tracking.
module nns_datapath #(
    parameter int MAX_RECORDS  = nns_pkg::DEF_MAX_RECORDS,
    parameter int MAX_FEATURES = nns_pkg::DEF_MAX_FEATURES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nns_pkg::nns_cmd_t                 cmd,
    output nns_pkg::nns_stat_t                stat,
    input  logic                              feed_mode,
    input  logic [nns_pkg::REC_IDX_W-1:0]     feed_record_index,
    input  logic [nns_pkg::FEAT_IDX_W-1:0]    feed_feature_index,
    input  logic signed [nns_pkg::VALUE_W-1:0] feed_value,
    input  logic                              cfg_write,
    input  logic [nns_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [nns_pkg::REG_DATA_W-1:0]    cfg_data,
    output logic [nns_pkg::REC_IDX_W-1:0]     best_record,
    output logic [nns_pkg::DIST_W-1:0]        best_distance_sq
);
    import nns_pkg::*;

    localparam int REC_W  = $clog2(MAX_RECORDS);
    localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int RN_W   = $clog2(MAX_RECORDS + 1);
    localparam int FN_W   = $clog2(MAX_FEATURES + 1);
    localparam int DEPTH  = MAX_RECORDS * MAX_FEATURES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = SQ_W + $clog2(MAX_FEATURES);
    localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    // Clamped counts.
    logic [RN_W-1:0] nr_reg;
    logic [FN_W-1:0] nf_reg;

    // Scan counters and running store address.
    logic [REC_W-1:0]  rec_reg;
    logic [FEAT_W-1:0] feat_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              feat_last;
    logic              rec_last;

    // Store ports.
    logic              ref_we;
    logic              qry_we;
    logic              rec_ok;
    logic              feat_ok;
    logic [ADDR_W-1:0] ref_waddr;
    logic [ADDR_W-1:0] ref_raddr;
    logic [VALUE_W-1:0] ref_rdata;
    logic [VALUE_W-1:0] qry_rdata;

    // Pipeline.
    nns_tag_t          tag0, tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [REC_W-1:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [VALUE_W:0]       diff_reg;
    logic signed [2*VALUE_W+1:0]   prod;
    logic [SQ_W-1:0]   sq_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  best_sum_reg;
    logic [REC_W-1:0]  best_idx_reg;
    logic              done_reg;
    logic [CMP_W-1:0]  best_wide;
    logic [REC_IDX_W-1:0] out_record_reg;
    logic [DIST_W-1:0]    out_dist_reg;

    // Count registers, clamped to 1 .. maximum when written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_reg <= RN_W'(1);
            nf_reg <= FN_W'(1);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_RECORD_COUNT)
            begin
                if (cfg_data == '0)
                begin
                    nr_reg <= RN_W'(1);
                end
                else if ({23'd0, cfg_data} > MAX_RECORDS)
                begin
                    nr_reg <= RN_W'(MAX_RECORDS);
                end
                else
                begin
                    nr_reg <= RN_W'(cfg_data);
                end
            end
            else if (cfg_index == REG_FEATURE_COUNT)
            begin
                if (cfg_data[FCOUNT_W-1:0] == '0)
                begin
                    nf_reg <= FN_W'(1);
                end
                else if ({27'd0, cfg_data[FCOUNT_W-1:0]} > MAX_FEATURES)
                begin
                    nf_reg <= FN_W'(MAX_FEATURES);
                end
                else
                begin
                    nf_reg <= FN_W'(cfg_data[FCOUNT_W-1:0]);
                end
            end
        end
    end

    // Store writes; out-of-range indexes store nothing.
    assign rec_ok    = ({24'd0, feed_record_index} < MAX_RECORDS);
    assign feat_ok   = ({28'd0, feed_feature_index} < MAX_FEATURES);
    assign ref_we    = cmd.write && feed_mode == MODE_LOAD && rec_ok && feat_ok;
    assign qry_we    = cmd.write && feed_mode == MODE_QUERY && feat_ok;
    assign ref_waddr = ADDR_W'(feed_record_index) * ADDR_W'(MAX_FEATURES)
                     + ADDR_W'(feed_feature_index);
    assign ref_raddr = base_reg + ADDR_W'(feat_reg);

    nns_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ref_store (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (feed_value),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    nns_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_FEATURES)
    ) u_qry_store (
        .clk   (clk),
        .we    (qry_we),
        .waddr (FEAT_W'(feed_feature_index)),
        .wdata (feed_value),
        .raddr (feat_reg),
        .rdata (qry_rdata)
    );

    // Scan counters walk features inside records.
    assign feat_last       = (FN_W'(feat_reg) == nf_reg - FN_W'(1));
    assign rec_last        = (RN_W'(rec_reg) == nr_reg - RN_W'(1));
    assign stat.issue_last = feat_last && rec_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg  <= '0;
            feat_reg <= '0;
            base_reg <= '0;
        end
        else if (cmd.start)
        begin
            rec_reg  <= '0;
            feat_reg <= '0;
            base_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (feat_last)
            begin
                feat_reg <= '0;
                rec_reg  <= rec_reg + REC_W'(1);
                base_reg <= base_reg + ADDR_W'(MAX_FEATURES);
            end
            else
            begin
                feat_reg <= feat_reg + FEAT_W'(1);
            end
        end
    end

    // Tags of the read issued this cycle.
    always_comb
    begin
        tag0.valid      = cmd.step;
        tag0.first_feat = (feat_reg == '0);
        tag0.last_feat  = feat_last;
        tag0.first_rec  = (rec_reg == '0);
        tag0.last_all   = feat_last && rec_last;
    end

    // Tag pipeline alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            done_reg <= tag4_reg.valid && tag4_reg.last_all;
        end
    end

    assign stat.done = done_reg;

    // Difference, square and per-record sum.
    assign prod = diff_reg * diff_reg;

    always_comb
    begin
        if (tag3_reg.first_feat)
        begin
            sum_next = SUM_W'(sq_reg);
        end
        else
        begin
            sum_next = sum_reg + SUM_W'(sq_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= rec_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        diff_reg <= $signed({ref_rdata[VALUE_W-1], ref_rdata})
                  - $signed({qry_rdata[VALUE_W-1], qry_rdata});
        sq_reg   <= prod[SQ_W-1:0];
        if (tag3_reg.valid)
        begin
            sum_reg <= sum_next;
        end
    end

    // Keep the smallest sum; a later record must be strictly smaller.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg <= '0;
            best_idx_reg <= '0;
        end
        else if (tag4_reg.valid && tag4_reg.last_feat)
        begin
            if (tag4_reg.first_rec || sum_reg < best_sum_reg)
            begin
                best_sum_reg <= sum_reg;
                best_idx_reg <= idx4_reg;
            end
        end
    end

    // Output register with saturation of the distance.
    assign best_wide = CMP_W'(best_sum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_record_reg <= REC_IDX_W'(best_idx_reg);
            if (best_wide > CMP_W'(DIST_MAX))
            begin
                out_dist_reg <= DIST_MAX;
            end
            else
            begin
                out_dist_reg <= DIST_W'(best_wide);
            end
        end
    end

    assign best_record      = out_record_reg;
    assign best_distance_sq = out_dist_reg;

endmodule

// File: sim/tb.sv
// Self-checking testbench of the nearest-neighbor search block with its own match predictor.
module tb;
    import nns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREC          = DEF_MAX_RECORDS;
    localparam int NFEAT         = DEF_MAX_FEATURES;
    localparam int ITEM_TARGET   = 450;
    localparam int RANDOM_SEARCH = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;

    // Register indexes that the block does not decode.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        TRAFFIC_FREE,
        TRAFFIC_SEND_GAPS,
        TRAFFIC_RECV_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    typedef struct packed {
        logic [REC_IDX_W-1:0] best_record;
        logic [DIST_W-1:0]    best_distance_sq;
    } match_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nns_feed_if   feed_ch ();
    nns_result_if res_ch ();
    nns_cfg_if    cfg_ch ();

    nearest_neighbor_search u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Mirror of the block's stores and registers.
    logic signed [VALUE_W-1:0] ref_mem [NREC][NFEAT];
    bit                        ref_written [NREC][NFEAT];
    logic signed [VALUE_W-1:0] query_vec [NFEAT];
    bit                        query_written [NFEAT];
    logic [REG_DATA_W-1:0]     rec_count_reg = 9'd1;
    logic [FCOUNT_W-1:0]       feat_count_reg = 5'd1;

    match_t      pending_matches [$];
    int unsigned mismatch_count = 0;
    int unsigned feed_beats = 0;
    int unsigned random_searches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Record and feature counts as the block applies them.
    function automatic int eff_records();
        int n;
        n = rec_count_reg;
        if (n == 0)
            return 1;
        return (n > NREC) ? NREC : n;
    endfunction

    function automatic int eff_features();
        int n;
        n = feat_count_reg;
        if (n == 0)
            return 1;
        return (n > NFEAT) ? NFEAT : n;
    endfunction

    // Scan all active records and keep the closest one, lowest index on a tie.
    function automatic match_t nearest_match();
        longint unsigned sum;
        longint unsigned best_sum;
        int              best_idx;
        int              d;
        match_t          m;
        best_sum = 0;
        best_idx = 0;
        for (int r = 0; r < eff_records(); r++)
        begin
            sum = 0;
            for (int f = 0; f < eff_features(); f++)
            begin
                d = int'(ref_mem[r][f]) - int'(query_vec[f]);
                sum += longint'(d) * longint'(d);
            end
            if (r == 0 || sum < best_sum)
            begin
                best_sum = sum;
                best_idx = r;
            end
        end
        m.best_record = best_idx[REC_IDX_W-1:0];
        m.best_distance_sq = (best_sum > DIST_MAX) ? DIST_MAX : best_sum[DIST_W-1:0];
        return m;
    endfunction

    // Feature values biased toward the extremes and toward small values that tie.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return $signed(16'($urandom_range(8)) - 16'd4);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic set_traffic(input traffic_t t);
        case (t)
            TRAFFIC_FREE:        begin send_idle_pct = 0;  stall_pct = 0;  end
            TRAFFIC_SEND_GAPS:   begin send_idle_pct = 52; stall_pct = 0;  end
            TRAFFIC_RECV_STALLS: begin send_idle_pct = 0;  stall_pct = 52; end
            default:             begin send_idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    // Send one feed beat and update the mirror once it is accepted.
    task automatic send_feed(input logic mode, input logic [REC_IDX_W-1:0] rec,
                             input logic [FEAT_IDX_W-1:0] feat,
                             input logic signed [VALUE_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            feed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        feed_ch.valid         <= 1'b1;
        feed_ch.mode          <= mode;
        feed_ch.record_index  <= rec;
        feed_ch.feature_index <= feat;
        feed_ch.value         <= value;
        feed_ch.last          <= last;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
        feed_beats++;
        if (mode == MODE_LOAD)
        begin
            if (int'(rec) < NREC && int'(feat) < NFEAT)
            begin
                ref_mem[rec][feat] = value;
                ref_written[rec][feat] = 1'b1;
            end
        end
        else
        begin
            if (int'(feat) < NFEAT)
            begin
                query_vec[feat] = value;
                query_written[feat] = 1'b1;
            end
            if (last)
                pending_matches.push_back(nearest_match());
        end
    endtask

    // Write one register once the block has gone quiet.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [REG_DATA_W-1:0] data);
        feed_ch.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_RECORD_COUNT:  rec_count_reg = data;
            REG_FEATURE_COUNT: feat_count_reg = data[FCOUNT_W-1:0];
            default:           ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    // Write every store entry that the next search reads and that is still unset.
    task automatic prepare_stores();
        for (int r = 0; r < eff_records(); r++)
            for (int f = 0; f < eff_features(); f++)
                if (!ref_written[r][f])
                    send_feed(MODE_LOAD, REC_IDX_W'(r), FEAT_IDX_W'(f), pick_value(),
                              1'($urandom_range(1)));
        for (int f = 0; f < eff_features(); f++)
            if (!query_written[f])
                send_feed(MODE_QUERY, 8'($urandom), FEAT_IDX_W'(f), pick_value(), 1'b0);
    endtask

    // One well-formed search with random content, sometimes with noise mixed in.
    task automatic random_search();
        int nr;
        int nf;
        int a;
        int b;
        prepare_stores();
        nr = eff_records();
        nf = eff_features();
        // Copy one record over another so that an exact tie is likely.
        if (nr > 1 && $urandom_range(3) == 0)
        begin
            a = $urandom_range(nr - 1);
            b = $urandom_range(nr - 1);
            for (int f = 0; f < nf; f++)
                send_feed(MODE_LOAD, REC_IDX_W'(b), FEAT_IDX_W'(f), ref_mem[a][f], 1'b0);
        end
        repeat ($urandom_range(2))
            send_feed(MODE_LOAD, REC_IDX_W'($urandom_range(nr - 1)),
                      FEAT_IDX_W'($urandom_range(nf - 1)), pick_value(),
                      1'($urandom_range(1)));
        if ($urandom_range(7) == 0)
        begin
            send_feed(MODE_LOAD, 8'($urandom), 4'($urandom), pick_value(), 1'b1);
            send_feed(MODE_QUERY, 8'($urandom), 4'($urandom), pick_value(), 1'b0);
        end
        repeat ($urandom_range(nf - 1))
            send_feed(MODE_QUERY, 8'($urandom), 4'($urandom), pick_value(), 1'b0);
        send_feed(MODE_QUERY, 8'($urandom), 4'($urandom), pick_value(), 1'b1);
    endtask

    // Default counts after reset, widest distance, and a last mark on a load.
    task automatic test_reset_defaults();
        set_traffic(TRAFFIC_FREE);
        send_feed(MODE_LOAD, 8'd0, 4'd0, 16'sh8000, 1'b0);
        send_feed(MODE_QUERY, 8'hFF, 4'd0, 16'sh7FFF, 1'b1);
        send_feed(MODE_LOAD, 8'd0, 4'd0, 16'sh0100, 1'b1);
        send_feed(MODE_QUERY, 8'd0, 4'd0, 16'sh0100, 1'b1);
    endtask

    // Writes to undecoded register indexes leave the counts alone.
    task automatic test_unknown_registers();
        write_register(REG_SPARE_2, 9'h1FF);
        write_register(REG_SPARE_3, 9'h000);
        send_feed(MODE_QUERY, 8'd0, 4'd0, 16'shFFFF, 1'b1);
    endtask

    // Zero counts act as one.
    task automatic test_zero_counts();
        write_register(REG_RECORD_COUNT, 9'd0);
        write_register(REG_FEATURE_COUNT, 9'd0);
        send_feed(MODE_QUERY, 8'd0, 4'd0, 16'sh7FFF, 1'b1);
    endtask

    // Equal distances resolve to the lower record index.
    task automatic test_tie_break();
        write_register(REG_RECORD_COUNT, 9'd3);
        write_register(REG_FEATURE_COUNT, 9'd1);
        send_feed(MODE_LOAD, 8'd1, 4'd0, 16'sd5, 1'b0);
        send_feed(MODE_LOAD, 8'd2, 4'd0, 16'sd5, 1'b0);
        send_feed(MODE_QUERY, 8'd0, 4'd0, 16'sd5, 1'b1);
        send_feed(MODE_LOAD, 8'd2, 4'd0, 16'sh0100, 1'b0);
        send_feed(MODE_QUERY, 8'd0, 4'd0, 16'sh0100, 1'b1);
    endtask

    // Full record range, then a count above the store size that saturates.
    task automatic test_wide_scan();
        set_traffic(TRAFFIC_BOTH);
        write_register(REG_RECORD_COUNT, 9'd256);
        write_register(REG_FEATURE_COUNT, 9'd1);
        repeat (4) random_search();
        write_register(REG_RECORD_COUNT, 9'd511);
        repeat (4) random_search();
    endtask

    // The receiver holds off while searches keep arriving, so the feed stalls.
    task automatic test_back_pressure();
        write_register(REG_RECORD_COUNT, 9'd4);
        write_register(REG_FEATURE_COUNT, 9'd2);
        set_traffic(TRAFFIC_FREE);
        prepare_stores();
        hold_requests++;
        repeat (8)
            send_feed(MODE_QUERY, 8'($urandom), 4'($urandom), pick_value(), 1'b1);
    endtask

    // Random configurations and searches under every traffic pattern.
    task automatic test_random_traffic();
        int phase;
        logic [REG_DATA_W-1:0] rc;
        phase = 0;
        while (feed_beats < ITEM_TARGET || random_searches < RANDOM_SEARCH)
        begin
            case ($urandom_range(7))
                0:       rc = 9'd0;
                1:       rc = 9'($urandom_range(24, 9));
                default: rc = 9'($urandom_range(8, 1));
            endcase
            write_register(REG_RECORD_COUNT, rc);
            write_register(REG_FEATURE_COUNT, {4'($urandom), 5'($urandom_range(31))});
            set_traffic(traffic_t'(phase % 4));
            repeat (2)
            begin
                random_search();
                random_searches++;
            end
            phase++;
        end
    endtask

    // Receiver ready, with random stalls and the long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_served = 0;
            hold_left = 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result beat with the oldest predicted match.
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: record %0d distance %0d",
                             res_ch.best_record, res_ch.best_distance_sq);
            end
            else
            begin
                want = pending_matches.pop_front();
                if (res_ch.best_record !== want.best_record
                    || res_ch.best_distance_sq !== want.best_distance_sq)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: record exp %0d got %0d, distance exp %0d got %0d",
                                 want.best_record, res_ch.best_record,
                                 want.best_distance_sq, res_ch.best_distance_sq);
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (feed_ch.valid && feed_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("nearest_neighbor_search test failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        feed_ch.valid         <= 1'b0;
        feed_ch.mode          <= MODE_LOAD;
        feed_ch.record_index  <= '0;
        feed_ch.feature_index <= '0;
        feed_ch.value         <= '0;
        feed_ch.last          <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_RECORD_COUNT;
        cfg_ch.data           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_unknown_registers();
        test_zero_counts();
        test_tie_break();
        test_wide_scan();
        test_back_pressure();
        test_random_traffic();

        feed_ch.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_matches.size() == 0)
            $display("nearest_neighbor_search test passed");
        else
            $display("nearest_neighbor_search test failed");
        $finish;
    end

endmodule
